// ===== design/pnq_pkg.sv =====
package pnq_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NAV_DEADZONE    = 3'd0,
    CFG_NAV_RELEASE     = 3'd1,
    CFG_SCROLL_DEADZONE = 3'd2,
    CFG_SCROLL_GAIN     = 3'd3,
    CFG_SCROLL_SPEED    = 3'd4,
    CFG_REPEAT_DELAY    = 3'd5,
    CFG_REPEAT_RATE     = 3'd6
  } cfg_idx_t;

  localparam logic [14:0] RST_NAV_DEADZONE    = 15'd16384;
  localparam logic [14:0] RST_NAV_RELEASE     = 15'd8192;
  localparam logic [14:0] RST_SCROLL_DEADZONE = 15'd4915;
  localparam logic [15:0] RST_SCROLL_GAIN     = 16'd4819;
  localparam logic [15:0] RST_SCROLL_SPEED    = 16'd1200;
  localparam logic [15:0] RST_REPEAT_DELAY    = 16'd400;
  localparam logic [15:0] RST_REPEAT_RATE     = 16'd100;

  // Direction codes, two-bit signed.
  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_POS  = 2'sb01;
  localparam logic signed [1:0] DIR_NEG  = 2'sb11;

  // Scroll delta is (num >> 22 + HALF) / DEN, with DEN the milliseconds per second.
  localparam logic [10:0] DELTA_DEN  = 11'd1000;
  localparam logic [40:0] DELTA_HALF = 41'd500;
  localparam int          QUO_W      = 31;

  // Reciprocal of DEN scaled by 2^41, truncated. Multiplying the dividend's upper
  // 32 bits by it and keeping the upper product word gives the quotient or up to
  // two less.
  localparam logic [31:0] DIV_RCP       = 32'd2199023255;
  // Smallest rounded dividend whose quotient no longer fits in QUO_W bits.
  localparam logic [40:0] DELTA_SAT_NUM = 41'd2147483648000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAPER_X,
    S_TAPER_Y,
    S_SQ_X,
    S_SQ_Y,
    S_SPEED,
    S_NUM_X,
    S_NUM_Y,
    S_RCP_X,
    S_RCP_Y,
    S_BACK_X,
    S_BACK_Y,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               dpad_up;
    logic               dpad_down;
    logic               dpad_left;
    logic               dpad_right;
    logic               button_a;
    logic               button_b;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [31:0]        now_ms;
    logic [15:0]        dt_ms;
  } sample_t;

  typedef struct packed {
    logic [14:0] start_thr;
    logic [14:0] keep_thr;
    logic [15:0] delay_ms;
    logic [15:0] rate_ms;
  } nav_cfg_t;

  typedef struct packed {
    logic signed [1:0] dir_x;
    logic signed [1:0] dir_y;
    logic              fire;
  } nav_res_t;

  // Magnitude of a Q1.15 value; -32768 maps to 32768.
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? (~v + 16'd1) : v;
    return r;
  endfunction

endpackage

// ===== design/pnq_if.sv =====
interface pnq_in_if;
  logic               valid;
  logic               ready;
  logic               dpad_up;
  logic               dpad_down;
  logic               dpad_left;
  logic               dpad_right;
  logic               button_a;
  logic               button_b;
  logic signed [15:0] left_x;
  logic signed [15:0] left_y;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic [31:0]        now_ms;
  logic [15:0]        dt_ms;

  modport source (
    output valid, dpad_up, dpad_down, dpad_left, dpad_right, button_a, button_b,
           left_x, left_y, right_x, right_y, now_ms, dt_ms,
    input  ready
  );
  modport sink (
    input  valid, dpad_up, dpad_down, dpad_left, dpad_right, button_a, button_b,
           left_x, left_y, right_x, right_y, now_ms, dt_ms,
    output ready
  );
endinterface

interface pnq_out_if;
  logic               valid;
  logic               ready;
  logic signed [1:0]  dir_x;
  logic signed [1:0]  dir_y;
  logic               fire;
  logic               press;
  logic               back;
  logic signed [15:0] scroll_x;
  logic signed [15:0] scroll_y;
  logic signed [31:0] scroll_dx;
  logic signed [31:0] scroll_dy;

  modport source (
    output valid, dir_x, dir_y, fire, press, back, scroll_x, scroll_y, scroll_dx, scroll_dy,
    input  ready
  );
  modport sink (
    input  valid, dir_x, dir_y, fire, press, back, scroll_x, scroll_y, scroll_dx, scroll_dy,
    output ready
  );
endinterface

interface pnq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pnq_pkg::CFG_IDX_W-1:0]   index;
  logic [15:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/pnq_mul.sv =====
module pnq_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= {32'd0, a} * {32'd0, b};
    end
  end

  assign p = p_r;
endmodule

// ===== design/pnq_div.sv =====
module pnq_div (
  input  logic [40:0]                x,
  input  logic [pnq_pkg::QUO_W-1:0]  q_est,
  input  logic [11:0]                prod_lo,
  output logic [pnq_pkg::QUO_W-1:0]  q
);
  import pnq_pkg::*;

  logic [11:0] rem;
  logic [1:0]  adj;
  logic        sat;

  // The reciprocal estimate is at most two below the true quotient, so the
  // remainder stays under 3000 and its low twelve bits are exact.
  assign rem = x[11:0] - prod_lo;
  assign sat = (x >= DELTA_SAT_NUM);

  always_comb begin
    priority if (rem >= {DELTA_DEN, 1'b0}) adj = 2'd2;
    else if (rem >= {1'b0, DELTA_DEN}) adj = 2'd1;
    else adj = 2'd0;
  end

  assign q = sat ? '1 : (q_est + QUO_W'(adj));
endmodule

// ===== design/pnq_nav.sv =====
module pnq_nav (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  pnq_pkg::sample_t   smp,
  input  pnq_pkg::nav_cfg_t  cfg,
  output pnq_pkg::nav_res_t  res
);
  import pnq_pkg::*;

  logic signed [1:0] held_x_r, held_x_nxt;
  logic signed [1:0] held_y_r, held_y_nxt;
  logic              active_r, active_nxt;
  logic [31:0]       due_r, due_nxt;
  nav_res_t          res_r, res_nxt;

  logic [15:0]       ax, ay, reach;
  logic signed [1:0] dx, dy;
  logic              stick, have, same, due_ok;
  logic [14:0]       thr;
  logic [31:0]       elapsed;

  assign ax = mag16(smp.left_x);
  assign ay = mag16(smp.left_y);

  always_comb begin
    dx    = DIR_NONE;
    dy    = DIR_NONE;
    reach = '0;
    stick = 1'b0;
    if (smp.dpad_right != smp.dpad_left) begin
      dx = smp.dpad_right ? DIR_POS : DIR_NEG;
    end else if (smp.dpad_down != smp.dpad_up) begin
      dy = smp.dpad_down ? DIR_POS : DIR_NEG;
    end else begin
      stick = 1'b1;
      if (ax >= ay) begin
        dx    = (smp.left_x == 16'sd0) ? DIR_NONE : (smp.left_x[15] ? DIR_NEG : DIR_POS);
        reach = ax;
      end else begin
        dy    = smp.left_y[15] ? DIR_NEG : DIR_POS;
        reach = ay;
      end
    end
  end

  // The held direction only needs the lower release threshold.
  assign same    = active_r && (held_x_r == dx) && (held_y_r == dy);
  assign thr     = same ? cfg.keep_thr : cfg.start_thr;
  assign have    = stick ? (((dx != DIR_NONE) || (dy != DIR_NONE)) && (reach >= {1'b0, thr}))
                         : 1'b1;
  assign elapsed = smp.now_ms - due_r;
  assign due_ok  = !elapsed[31];

  always_comb begin
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    active_nxt = active_r;
    due_nxt    = due_r;
    res_nxt    = res_r;
    if (step) begin
      res_nxt.dir_x = have ? dx : DIR_NONE;
      res_nxt.dir_y = have ? dy : DIR_NONE;
      res_nxt.fire  = 1'b0;
      if (!have) begin
        active_nxt = 1'b0;
      end else if (!same) begin
        active_nxt   = 1'b1;
        held_x_nxt   = dx;
        held_y_nxt   = dy;
        due_nxt      = smp.now_ms + {16'd0, cfg.delay_ms};
        res_nxt.fire = 1'b1;
      end else if (due_ok) begin
        due_nxt      = due_r + {16'd0, cfg.rate_ms};
        res_nxt.fire = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r <= DIR_NONE;
      held_y_r <= DIR_NONE;
      active_r <= 1'b0;
      due_r    <= '0;
      res_r    <= '0;
    end else begin
      held_x_r <= held_x_nxt;
      held_y_r <= held_y_nxt;
      active_r <= active_nxt;
      due_r    <= due_nxt;
      res_r    <= res_nxt;
    end
  end

  assign res = res_r;
endmodule

// ===== design/pad_navigation_qualifier_repeat_top.sv =====
// Gamepad navigation qualifier with typematic repeat and right-stick scroll.
// in_chan carries one gamepad sample per beat; out_chan returns exactly one
// result beat per sample. cfg_chan writes one register per beat (index 0..6,
// other indexes are dropped) and is always ready; write it only while idle.
// A sample is accepted only when the sequencer is idle, then it runs over a
// single shared 32x32 multiplier: seven products for the taper and the scroll
// numerators, then two per axis for the divide by 1000 (a reciprocal estimate
// and its back-multiply), with a small compare stage fixing the quotient.
// The result reaches out_chan through the output register loaded in the done
// state, and the next sample is taken only back in idle, so no sample is taken
// before the last one is through; the eleven multiplier passes set the length.
// The result sits in an output register, so the next sample is accepted even
// while out_chan is stalled; a finished result then waits until the register
// frees up. Reset is synchronous: the sequencer goes idle, the output register
// empties, the held direction and repeat schedule clear, and the registers
// return to their defaults.
module pad_navigation_qualifier_repeat_top (
  input  logic       clk,
  input  logic       rst_n,
  pnq_in_if.sink     in_chan,
  pnq_out_if.source  out_chan,
  pnq_cfg_if.sink    cfg_chan
);
  import pnq_pkg::*;

  // Configuration registers.
  logic [14:0] nav_dz_r, nav_rel_r, scr_dz_r;
  logic [15:0] scr_gain_r, scr_speed_r, rep_delay_r, rep_rate_r;

  state_t      state_r, state_nxt;
  sample_t     smp_r;

  logic [31:0] mul_a, mul_b;
  logic        mul_en;
  logic [63:0] mul_p;

  logic [40:0] div_x;
  logic [40:0] div_num;
  logic [QUO_W-1:0] div_est;
  logic [QUO_W-1:0] div_q;

  logic        nav_step;
  nav_cfg_t    nav_cfg;
  nav_res_t    nav_res;

  logic [15:0] mag_x, mag_y, diff_x, diff_y;
  logic        zero_x, zero_y;
  logic [32:0] t_round;
  logic [20:0] t_full;
  logic [14:0] t_sat;

  logic [14:0] tmag_x_r, tmag_y_r;
  logic [29:0] mx_r, my_r;
  logic [31:0] sd_r;
  logic [40:0] numx_r, numy_r;
  logic [QUO_W-1:0] qex_r, qey_r;
  logic [QUO_W-1:0] qx_r;

  logic        in_ready, load_out;
  logic        out_valid_r;
  logic signed [1:0]  o_dir_x_r, o_dir_y_r;
  logic               o_fire_r, o_press_r, o_back_r;
  logic signed [15:0] o_sx_r, o_sy_r;
  logic signed [31:0] o_dx_r, o_dy_r;

  // Configuration writes.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nav_dz_r    <= RST_NAV_DEADZONE;
      nav_rel_r   <= RST_NAV_RELEASE;
      scr_dz_r    <= RST_SCROLL_DEADZONE;
      scr_gain_r  <= RST_SCROLL_GAIN;
      scr_speed_r <= RST_SCROLL_SPEED;
      rep_delay_r <= RST_REPEAT_DELAY;
      rep_rate_r  <= RST_REPEAT_RATE;
    end else if (cfg_chan.valid) begin
      unique case (cfg_idx_t'(cfg_chan.index))
        CFG_NAV_DEADZONE:    nav_dz_r    <= cfg_chan.data[14:0];
        CFG_NAV_RELEASE:     nav_rel_r   <= cfg_chan.data[14:0];
        CFG_SCROLL_DEADZONE: scr_dz_r    <= cfg_chan.data[14:0];
        CFG_SCROLL_GAIN:     scr_gain_r  <= cfg_chan.data;
        CFG_SCROLL_SPEED:    scr_speed_r <= cfg_chan.data;
        CFG_REPEAT_DELAY:    rep_delay_r <= cfg_chan.data;
        CFG_REPEAT_RATE:     rep_rate_r  <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Shared units.
  pnq_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // The horizontal quotient is fixed up while the vertical back-multiply runs,
  // the vertical one while the result is loaded.
  assign div_num = (state_r == S_BACK_Y) ? numx_r : numy_r;
  assign div_est = (state_r == S_BACK_Y) ? qex_r : qey_r;

  pnq_div u_div (
    .x       (div_num),
    .q_est   (div_est),
    .prod_lo (mul_p[11:0]),
    .q       (div_q)
  );

  assign nav_cfg.start_thr = nav_dz_r;
  assign nav_cfg.keep_thr  = nav_rel_r;
  assign nav_cfg.delay_ms  = rep_delay_r;
  assign nav_cfg.rate_ms   = rep_rate_r;

  pnq_nav u_nav (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (nav_step),
    .smp   (smp_r),
    .cfg   (nav_cfg),
    .res   (nav_res)
  );

  // Taper datapath around the shared multiplier.
  assign mag_x   = mag16(smp_r.right_x);
  assign mag_y   = mag16(smp_r.right_y);
  assign zero_x  = (mag_x <= {1'b0, scr_dz_r});
  assign zero_y  = (mag_y <= {1'b0, scr_dz_r});
  assign diff_x  = mag_x - {1'b0, scr_dz_r};
  assign diff_y  = mag_y - {1'b0, scr_dz_r};
  assign t_round = {1'b0, mul_p[31:0]} + 33'd2048;
  assign t_full  = t_round[32:12];
  assign t_sat   = (t_full > 21'd32767) ? 15'h7FFF : t_full[14:0];

  // The product register holds the scaled square; drop the Q fraction and round.
  assign div_x   = {1'b0, mul_p[61:22]} + DELTA_HALF;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_chan.valid) state_nxt = S_TAPER_X;
      S_TAPER_X: state_nxt = S_TAPER_Y;
      S_TAPER_Y: state_nxt = S_SQ_X;
      S_SQ_X:    state_nxt = S_SQ_Y;
      S_SQ_Y:    state_nxt = S_SPEED;
      S_SPEED:   state_nxt = S_NUM_X;
      S_NUM_X:   state_nxt = S_NUM_Y;
      S_NUM_Y:   state_nxt = S_RCP_X;
      S_RCP_X:   state_nxt = S_RCP_Y;
      S_RCP_Y:   state_nxt = S_BACK_X;
      S_BACK_X:  state_nxt = S_BACK_Y;
      S_BACK_Y:  state_nxt = S_DONE;
      S_DONE:    if (!out_valid_r || out_chan.ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_en    = 1'b0;
    nav_step  = 1'b0;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE:    in_ready = 1'b1;
      S_TAPER_X: begin
        mul_a    = {16'd0, diff_x};
        mul_b    = {16'd0, scr_gain_r};
        mul_en   = 1'b1;
        nav_step = 1'b1;
      end
      S_TAPER_Y: begin
        mul_a  = {16'd0, diff_y};
        mul_b  = {16'd0, scr_gain_r};
        mul_en = 1'b1;
      end
      S_SQ_X: begin
        mul_a  = {17'd0, tmag_x_r};
        mul_b  = {17'd0, tmag_x_r};
        mul_en = 1'b1;
      end
      S_SQ_Y: begin
        mul_a  = {17'd0, tmag_y_r};
        mul_b  = {17'd0, tmag_y_r};
        mul_en = 1'b1;
      end
      S_SPEED: begin
        mul_a  = {16'd0, scr_speed_r};
        mul_b  = {16'd0, smp_r.dt_ms};
        mul_en = 1'b1;
      end
      S_NUM_X: begin
        mul_a  = {2'd0, mx_r};
        mul_b  = mul_p[31:0];
        mul_en = 1'b1;
      end
      S_NUM_Y: begin
        mul_a  = {2'd0, my_r};
        mul_b  = sd_r;
        mul_en = 1'b1;
      end
      S_RCP_X: begin
        mul_a  = numx_r[40:9];
        mul_b  = DIV_RCP;
        mul_en = 1'b1;
      end
      S_RCP_Y: begin
        mul_a  = numy_r[40:9];
        mul_b  = DIV_RCP;
        mul_en = 1'b1;
      end
      S_BACK_X: begin
        mul_a  = {1'b0, qex_r};
        mul_b  = {21'd0, DELTA_DEN};
        mul_en = 1'b1;
      end
      S_BACK_Y: begin
        mul_a  = {1'b0, qey_r};
        mul_b  = {21'd0, DELTA_DEN};
        mul_en = 1'b1;
      end
      S_DONE:    load_out = !out_valid_r || out_chan.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      smp_r.dpad_up    <= in_chan.dpad_up;
      smp_r.dpad_down  <= in_chan.dpad_down;
      smp_r.dpad_left  <= in_chan.dpad_left;
      smp_r.dpad_right <= in_chan.dpad_right;
      smp_r.button_a   <= in_chan.button_a;
      smp_r.button_b   <= in_chan.button_b;
      smp_r.left_x     <= in_chan.left_x;
      smp_r.left_y     <= in_chan.left_y;
      smp_r.right_x    <= in_chan.right_x;
      smp_r.right_y    <= in_chan.right_y;
      smp_r.now_ms     <= in_chan.now_ms;
      smp_r.dt_ms      <= in_chan.dt_ms;
    end
    if (state_r == S_TAPER_Y) tmag_x_r <= zero_x ? 15'd0 : t_sat;
    if (state_r == S_SQ_X)    tmag_y_r <= zero_y ? 15'd0 : t_sat;
    if (state_r == S_SQ_Y)    mx_r     <= mul_p[29:0];
    if (state_r == S_SPEED)   my_r     <= mul_p[29:0];
    if (state_r == S_NUM_X)   sd_r     <= mul_p[31:0];
    if (state_r == S_NUM_Y)   numx_r   <= div_x;
    if (state_r == S_RCP_X)   numy_r   <= div_x;
    if (state_r == S_RCP_Y)   qex_r    <= mul_p[62:32];
    if (state_r == S_BACK_X)  qey_r    <= mul_p[62:32];
    if (state_r == S_BACK_Y)  qx_r     <= div_q;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_dir_x_r <= nav_res.dir_x;
      o_dir_y_r <= nav_res.dir_y;
      o_fire_r  <= nav_res.fire;
      o_press_r <= smp_r.button_a;
      o_back_r  <= smp_r.button_b;
      o_sx_r    <= smp_r.right_x[15] ? (16'sd0 - $signed({1'b0, tmag_x_r}))
                                     : $signed({1'b0, tmag_x_r});
      o_sy_r    <= smp_r.right_y[15] ? (16'sd0 - $signed({1'b0, tmag_y_r}))
                                     : $signed({1'b0, tmag_y_r});
      o_dx_r    <= smp_r.right_x[15] ? (32'sd0 - $signed({1'b0, qx_r}))
                                     : $signed({1'b0, qx_r});
      o_dy_r    <= smp_r.right_y[15] ? (32'sd0 - $signed({1'b0, div_q}))
                                     : $signed({1'b0, div_q});
    end
  end

  assign in_chan.ready      = in_ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.dir_x     = o_dir_x_r;
  assign out_chan.dir_y     = o_dir_y_r;
  assign out_chan.fire      = o_fire_r;
  assign out_chan.press     = o_press_r;
  assign out_chan.back      = o_back_r;
  assign out_chan.scroll_x  = o_sx_r;
  assign out_chan.scroll_y  = o_sy_r;
  assign out_chan.scroll_dx = o_dx_r;
  assign out_chan.scroll_dy = o_dy_r;

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(o_dx_r) && $stable(o_dy_r)))
    else $error("result beat changed while stalled");

  a_fire_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!o_fire_r || o_dir_x_r != DIR_NONE || o_dir_y_r != DIR_NONE))
    else $error("navigation step fired with no direction");

  a_single_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_dir_x_r == DIR_NONE || o_dir_y_r == DIR_NONE))
    else $error("direction on both axes at once");

  a_scroll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_sx_r != 16'sh8000 && o_sy_r != 16'sh8000))
    else $error("tapered scroll axis out of range");
`endif
endmodule
